[rtl/core/dtps_pkg.sv]
// shared constants, codes and types of the depth-tested pixel store
// depends on nothing; imported by depth_tested_pixel_store

package dtps_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(PLANE_DEPTH);
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int Y_W         = $clog2(MAX_HEIGHT);
    localparam int DIMW_W      = $clog2(MAX_WIDTH + 1);
    localparam int DIMH_W      = $clog2(MAX_HEIGHT + 1);

    localparam int FRAME_DIM_W = 9;
    localparam int BIAS_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_W     = 16;
    localparam int DEPTH_IN_W  = 32;
    localparam int DEPTH_W     = 31;
    localparam int COLOR_W     = 32;
    localparam int CMD_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DEPTH_BIAS   = 2'd2
    } t_cfg_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 3'd0,
        CMD_ZWRITE    = 3'd1,
        CMD_CLR_COLOR = 3'd2,
        CMD_CLR_DEPTH = 3'd3,
        CMD_READ      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_OOB    = 2'd1,
        ST_REJECT = 2'd2,
        ST_READ   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_CLEAR = 2'd2
    } t_state;

endpackage

[rtl/core/dtps_ram.sv]
// generic simple dual-port ram: one write port, one read port with registered data
// depends on nothing

module dtps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/depth_tested_pixel_store.sv]
// top level of the depth-tested pixel store: config registers, command sequencer
// depends on dtps_pkg and dtps_ram (one instance per plane)

// A command is taken when i_start is high and o_busy is low. Plain writes,
// depth-tested writes and reads each read the plane entry in the accept cycle
// and compare and write it back in the next, so a new command is taken only
// once the block is idle again. The result strobe o_result_valid is high for
// one cycle, follows the S_EVAL state for these commands and cannot be held off.
// A clear sweeps the active frame one pixel per cycle through the write port
// of the plane, so the block stays busy until every pixel of the active
// frame (width and height capped at their maximum) has been written.
// A clear of an empty frame and an unknown command answer in the cycle after
// the accept. Every plane entry must be written (by a write or a clear)
// before it is read or depth-tested.

module depth_tested_pixel_store
    import dtps_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [CMD_W-1:0]             i_cmd,
    input  logic signed [COORD_W-1:0]    i_pos_x,
    input  logic signed [COORD_W-1:0]    i_pos_y,
    input  logic signed [DEPTH_IN_W-1:0] i_new_depth,
    input  logic [COLOR_W-1:0]           i_pixel_color,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_result_valid,
    output logic [1:0]                   o_status,
    output logic [COLOR_W-1:0]           o_read_color,
    output logic [DEPTH_W-1:0]           o_read_depth
);

    localparam int PROD_W = Y_W + DIMW_W;
    localparam int AREA_W = DIMW_W + DIMH_W;

    // configuration
    logic [FRAME_DIM_W-1:0] r_frame_width;
    logic [FRAME_DIM_W-1:0] r_frame_height;
    logic [BIAS_W-1:0]      r_depth_bias;

    // sequencer
    t_state                 r_state, n_state;
    logic [CMD_W-1:0]       r_cmd, n_cmd;
    logic                   r_inb, n_inb;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [DEPTH_IN_W-1:0]  r_depth, n_depth;
    logic [COLOR_W-1:0]     r_color, n_color;
    logic [ADDR_W-1:0]      r_fill, n_fill;
    logic [ADDR_W-1:0]      r_fill_last, n_fill_last;

    // result register
    logic                   r_valid, n_valid;
    t_status                r_status, n_status;
    logic [COLOR_W-1:0]     r_rcolor, n_rcolor;
    logic [DEPTH_W-1:0]     r_rdepth, n_rdepth;

    // plane ports
    logic                   c_we, d_we;
    logic [ADDR_W-1:0]      waddr;
    logic [DEPTH_W-1:0]     d_wdata;
    logic [COLOR_W-1:0]     c_rdata;
    logic [DEPTH_W-1:0]     d_rdata;

    // locate
    logic [DIMW_W-1:0]      act_w;
    logic [DIMH_W-1:0]      act_h;
    logic                   x_ok, y_ok;
    logic [PROD_W-1:0]      row_base;
    logic [ADDR_W-1:0]      loc_addr;
    logic [AREA_W-1:0]      area;
    logic                   accept;

    // depth test
    logic [DEPTH_IN_W-1:0]  z_limit;
    logic                   z_pos, z_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_DIM_W'(256);
            r_frame_height <= FRAME_DIM_W'(256);
            r_depth_bias   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_DIM_W-1:0];
                REG_DEPTH_BIAS:   r_depth_bias   <= i_cfg_data[BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    // oversized frame acts as the maximum
    always_comb begin
        act_w = (32'(r_frame_width) > 32'(MAX_WIDTH)) ? DIMW_W'(MAX_WIDTH)
                                                       : DIMW_W'(r_frame_width);
        act_h = (32'(r_frame_height) > 32'(MAX_HEIGHT)) ? DIMH_W'(MAX_HEIGHT)
                                                         : DIMH_W'(r_frame_height);
        x_ok     = !i_pos_x[COORD_W-1] && (32'(i_pos_x) < 32'(act_w));
        y_ok     = !i_pos_y[COORD_W-1] && (32'(i_pos_y) < 32'(act_h));
        row_base = PROD_W'(i_pos_y[Y_W-1:0]) * PROD_W'(act_w);
        loc_addr = ADDR_W'(row_base + PROD_W'(i_pos_x[X_W-1:0]));
        area     = AREA_W'(act_w) * AREA_W'(act_h);
        accept   = i_start && (r_state == S_IDLE);
    end

    always_comb begin
        z_limit = DEPTH_IN_W'(d_rdata) + DEPTH_IN_W'(r_depth_bias);
        z_pos   = !r_depth[DEPTH_IN_W-1] && (r_depth != '0);
        z_pass  = {1'b0, r_depth[DEPTH_W-1:0]} > z_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_inb       <= n_inb;
        r_addr      <= n_addr;
        r_depth     <= n_depth;
        r_color     <= n_color;
        r_fill_last <= n_fill_last;
        r_status    <= n_status;
        r_rcolor    <= n_rcolor;
        r_rdepth    <= n_rdepth;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_inb       = r_inb;
        n_addr      = r_addr;
        n_depth     = r_depth;
        n_color     = r_color;
        n_fill      = r_fill;
        n_fill_last = r_fill_last;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_rcolor    = r_rcolor;
        n_rdepth    = r_rdepth;
        c_we        = 1'b0;
        d_we        = 1'b0;
        waddr       = r_addr;
        d_wdata     = r_depth[DEPTH_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd       = i_cmd;
                    n_inb       = x_ok && y_ok;
                    n_addr      = loc_addr;
                    n_depth     = i_new_depth;
                    n_color     = i_pixel_color;
                    n_fill_last = ADDR_W'(area - AREA_W'(1));
                    case (i_cmd)
                        CMD_WRITE, CMD_ZWRITE, CMD_READ: begin
                            n_state = S_EVAL;
                        end
                        CMD_CLR_COLOR, CMD_CLR_DEPTH: begin
                            if (act_w == '0 || act_h == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_DONE;
                                n_rcolor = '0;
                                n_rdepth = '0;
                            end else begin
                                n_state = S_CLEAR;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_DONE;
                            n_rcolor = '0;
                            n_rdepth = '0;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_DONE;
                n_rcolor = '0;
                n_rdepth = '0;
                if (!r_inb) begin
                    n_status = ST_OOB;
                end else begin
                    case (r_cmd)
                        CMD_WRITE: begin
                            c_we = 1'b1;
                        end
                        CMD_ZWRITE: begin
                            if (z_pos && z_pass) begin
                                c_we = 1'b1;
                                d_we = 1'b1;
                            end else begin
                                n_status = ST_REJECT;
                            end
                        end
                        CMD_READ: begin
                            n_status = ST_READ;
                            n_rcolor = c_rdata;
                            n_rdepth = d_rdata;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                waddr   = r_fill;
                d_wdata = '0;
                c_we    = (r_cmd == CMD_CLR_COLOR);
                d_we    = (r_cmd == CMD_CLR_DEPTH);
                if (r_fill == r_fill_last) begin
                    n_fill   = '0;
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_DONE;
                    n_rcolor = '0;
                    n_rdepth = '0;
                end else begin
                    n_fill = r_fill + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    dtps_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PLANE_DEPTH)
    ) u_color_plane (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (waddr),
        .i_wdata (r_color),
        .i_raddr (loc_addr),
        .o_rdata (c_rdata)
    );

    dtps_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (PLANE_DEPTH)
    ) u_depth_plane (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (waddr),
        .i_wdata (d_wdata),
        .i_raddr (loc_addr),
        .o_rdata (d_rdata)
    );

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_read_color   = r_rcolor;
    assign o_read_depth   = r_rdepth;

    // planes are only written while a transaction is in flight
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(c_we || d_we))
        else $error("plane written while idle");

    // sweep position returns to zero after each clear
    a_fill_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_fill == '0))
        else $error("fill counter not zero outside a clear");

    // read, write and depth write are answered in the cycle after S_EVAL, back in idle
    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_valid && r_state == S_IDLE))
        else $error("lookup did not produce a result");

    // read data status only follows a read
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_READ) |-> (r_cmd == CMD_READ))
        else $error("read status for a non-read transaction");

    // a clear writes exactly one plane per cycle
    a_clear_one_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> $onehot({c_we, d_we}))
        else $error("clear did not write exactly one plane");

endmodule
